FILE: rtl/mdd_pkg.sv
// Package for the matrix diagonal DFT core: sizes, widths and the Q1.15 cosine table.
// No dependencies; used by the stream interfaces and the core.
package mdd_pkg;

  // Matrix edge, a power of two that divides the table size
  localparam int SIZE         = 32;
  localparam int SIZE_LOG2    = $clog2(SIZE);
  localparam int TABLE_POINTS = 64;
  localparam int TW_IDX_W     = $clog2(TABLE_POINTS);
  localparam int TW_STEP_LOG2 = TW_IDX_W - SIZE_LOG2;

  // Payload and datapath widths
  localparam int VAL_W       = 24;
  localparam int FREQ_W      = 5;
  localparam int TW_W        = 16;
  localparam int TW_FRAC     = 15;
  localparam int DIAG_W      = VAL_W + SIZE_LOG2;
  localparam int PROD_W      = DIAG_W + TW_W;
  localparam int ACC_W       = PROD_W + SIZE_LOG2;
  localparam int SUM_W       = ACC_W + 1;
  localparam int OP_W        = SIZE_LOG2 + 1;
  localparam int SCALE_SHIFT = 2 * SIZE_LOG2 + TW_FRAC;

  // Quarter-wave offset that turns a cosine lookup into a sine lookup
  localparam logic [TW_IDX_W-1:0] SIN_OFFSET = TW_IDX_W'(TABLE_POINTS * 3 / 4);

  // First quadrant of cos, Q1.15, +1.0 held as 32767
  localparam logic signed [TW_W-1:0] QUARTER_COS [17] = '{
    16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
    16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
    16'sd12540, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
  };

  // Full-wave cosine from the quarter table
  function automatic logic signed [TW_W-1:0] cos_q15(input logic [TW_IDX_W-1:0] j);
    logic [3:0] r;
    logic [4:0] rm;
    r  = j[3:0];
    rm = 5'd16 - {1'b0, r};
    case (j[5:4])
      2'd0:    return QUARTER_COS[r];
      2'd1:    return -QUARTER_COS[rm];
      2'd2:    return -QUARTER_COS[r];
      default: return QUARTER_COS[rm];
    endcase
  endfunction

endpackage

FILE: rtl/mdd_in_if.sv
// Input stream of the matrix diagonal DFT core: one matrix element per beat.
// Depends on mdd_pkg for field widths.
interface mdd_in_if import mdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] element_value;
  logic                    last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

FILE: rtl/mdd_out_if.sv
// Output stream of the matrix diagonal DFT core: one frequency bin per beat.
// Depends on mdd_pkg for field widths.
interface mdd_out_if import mdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] real_part;
  logic signed [VAL_W-1:0] imag_part;
  logic [FREQ_W-1:0]       freq_index;
  logic                    last_result;

  modport source (output valid, output real_part, output imag_part, output freq_index,
                  output last_result, input ready);
  modport sink   (input valid, input real_part, input imag_part, input freq_index,
                  input last_result, output ready);
endinterface

FILE: rtl/matrix_diagonal_dft_core.sv
// Matrix diagonal DFT core: diagonal-sum store plus a shared multiply-accumulate sequencer.
// Depends on mdd_pkg, mdd_in_if and mdd_out_if.
//
//   channel | direction | beat payload
//   in_i    | sink      | element_value, last_element
//   out_o   | source    | real_part, imag_part, freq_index, last_result
//
// Elements are taken one per cycle; each adds into diagonal (row - col) mod SIZE.
// After the last element, one 29x16-bit multiplier (45-bit product) runs 2*SIZE products per bin
// (cos then sin for each diagonal), and each bin then waits for out_o.ready;
// input is not ready until the last bin is taken.
// Reset (rst_ni low, asynchronous) empties the store and zeroes the counters.
module matrix_diagonal_dft_core import mdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mdd_in_if.sink    in_i,
  mdd_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_ACC,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_OUT
  } state_e;

  localparam logic [SIZE_LOG2-1:0] K_LAST  = SIZE_LOG2'(SIZE - 1);
  localparam logic [OP_W-1:0]      OP_LAST = OP_W'(2 * SIZE - 1);

  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(64'sd1 <<< (SCALE_SHIFT - 1));
  localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'(64'sd8388607);
  localparam logic signed [SUM_W-1:0] SAT_MIN  = SUM_W'(-64'sd8388608);

  // Round to nearest (ties up), scale down and saturate to the output range
  function automatic logic signed [VAL_W-1:0] sat_round(input logic signed [ACC_W-1:0] a);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] t;
    s = SUM_W'(a) + RND_BIAS;
    t = s >>> SCALE_SHIFT;
    if (t > SAT_MAX) return VAL_W'(SAT_MAX);
    if (t < SAT_MIN) return VAL_W'(SAT_MIN);
    return VAL_W'(t);
  endfunction

  state_e                   state_q;
  logic [SIZE_LOG2-1:0]     row_q, col_q;
  logic [SIZE_LOG2-1:0]     k_q, ph_q;
  logic [OP_W-1:0]          op_cnt_q;
  logic [SIZE-1:0]          diag_vld_q;
  logic                     s1_vld_q, s1_im_q, s1_last_q;
  logic                     s2_vld_q, s2_im_q, s2_last_q;

  logic signed [DIAG_W-1:0] diag_q [SIZE];
  logic signed [DIAG_W-1:0] opa_q;
  logic signed [TW_W-1:0]   opb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [VAL_W-1:0]  real_q, imag_q;
  logic [FREQ_W-1:0]        freq_q;
  logic                     last_q;

  logic                     in_beat, out_beat, acc_clr;
  logic [SIZE_LOG2-1:0]     wr_addr, rd_addr;
  logic signed [DIAG_W-1:0] wr_cur, rd_val;
  logic                     op_im;
  logic [TW_IDX_W-1:0]      tw_idx;

  assign in_i.ready = (state_q == S_ACC);
  assign in_beat    = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == S_OUT);
  assign out_beat    = out_o.valid && out_o.ready;

  assign out_o.real_part   = real_q;
  assign out_o.imag_part   = imag_q;
  assign out_o.freq_index  = freq_q;
  assign out_o.last_result = last_q;

  // Store addressing: accumulate on the diagonal, read by diagonal index while transforming
  assign wr_addr = row_q - col_q;
  assign wr_cur  = diag_vld_q[wr_addr] ? diag_q[wr_addr] : '0;
  assign rd_addr = op_cnt_q[OP_W-1:1];
  assign rd_val  = diag_vld_q[rd_addr] ? diag_q[rd_addr] : '0;

  // Twiddle index: phase k*d mod SIZE scaled to the table, sine a quarter wave back
  assign op_im  = op_cnt_q[0];
  assign tw_idx = op_im ? TW_IDX_W'((TW_IDX_W'(ph_q) << TW_STEP_LOG2) + SIN_OFFSET)
                        : TW_IDX_W'(ph_q) << TW_STEP_LOG2;

  // Clear the accumulators whenever a new bin starts
  assign acc_clr = (in_beat && in_i.last_element) ||
                   (out_beat && (k_q != K_LAST));

  // Sequencer: state, counters, valid bits and pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_ACC;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
      ph_q       <= '0;
      op_cnt_q   <= '0;
      diag_vld_q <= '0;
      s1_vld_q   <= 1'b0;
      s1_im_q    <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_im_q    <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      // advance the product pipeline tags
      s1_vld_q  <= (state_q == S_MAC);
      s1_im_q   <= op_im;
      s1_last_q <= (rd_addr == K_LAST);
      s2_vld_q  <= s1_vld_q;
      s2_im_q   <= s1_im_q;
      s2_last_q <= s1_last_q;

      case (state_q)
        S_ACC: begin
          if (in_beat) begin
            diag_vld_q[wr_addr] <= 1'b1;
            col_q <= col_q + 1'b1;
            if (col_q == K_LAST) row_q <= row_q + 1'b1;
            if (in_i.last_element) begin
              k_q      <= '0;
              ph_q     <= '0;
              op_cnt_q <= '0;
              state_q  <= S_MAC;
            end
          end
        end
        S_MAC: begin
          // step phase by k after the sine product of each diagonal
          op_cnt_q <= op_cnt_q + 1'b1;
          if (op_im) ph_q <= ph_q + k_q;
          if (op_cnt_q == OP_LAST) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (s2_vld_q && s2_im_q && s2_last_q) state_q <= S_ROUND;
        end
        S_ROUND: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_beat) begin
            if (k_q == K_LAST) begin
              // run done: empty the store and restart the counters
              diag_vld_q <= '0;
              row_q      <= '0;
              col_q      <= '0;
              state_q    <= S_ACC;
            end else begin
              k_q      <= k_q + 1'b1;
              ph_q     <= '0;
              op_cnt_q <= '0;
              state_q  <= S_MAC;
            end
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  // Diagonal-sum store
  always_ff @(posedge clk_i) begin
    if (in_beat) diag_q[wr_addr] <= DIAG_W'(wr_cur + DIAG_W'(in_i.element_value));
  end

  // Shared multiply-accumulate datapath and output register
  always_ff @(posedge clk_i) begin
    opa_q  <= rd_val;
    opb_q  <= cos_q15(tw_idx);
    prod_q <= opa_q * opb_q;
    if (acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s2_vld_q) begin
      if (s2_im_q) acc_im_q <= acc_im_q + ACC_W'(prod_q);
      else         acc_re_q <= acc_re_q + ACC_W'(prod_q);
    end
    if (state_q == S_ROUND) begin
      real_q <= sat_round(acc_re_q);
      imag_q <= sat_round(acc_im_q);
      freq_q <= FREQ_W'(k_q);
      last_q <= (k_q == K_LAST);
    end
  end

endmodule
